// ===== hdl/crdp_pkg.sv =====
package crdp_pkg;

   // Register indexes on the csr port
   localparam logic [7:0] CSR_ENTRY_CAP    = 8'd0;
   localparam logic [7:0] CSR_OWNER_KEY_ID = 8'd1;

   localparam logic [15:0] ENTRY_CAP_RESET    = 16'hFFFF;
   localparam logic [5:0]  OWNER_KEY_ID_RESET = 6'd3;

   localparam logic [5:0] KEY_TEXT_DESC = 6'd1;

   // Descriptor search status as reported on the result word
   localparam logic [1:0] ST_PENDING = 2'd0;
   localparam logic [1:0] ST_FOUND   = 2'd1;
   localparam logic [1:0] ST_ABSENT  = 2'd2;

   typedef enum logic [1:0] {
      KT_IMMEDIATE = 2'd0,
      KT_OFFSET    = 2'd1,
      KT_LEAF      = 2'd2,
      KT_DIRECTORY = 2'd3
   } key_kind_type;

   typedef enum logic [1:0] {
      PH_SEARCH = 2'd0,
      PH_OWNER  = 2'd1,
      PH_FOUND  = 2'd2,
      PH_ABSENT = 2'd3
   } phase_type;

   typedef struct packed {
      logic [31:0] quadlet_word;
      logic        is_header;
      logic        is_last;
      logic [7:0]  dir_base;
   } req_type;

   typedef struct packed {
      logic        entry_valid;
      logic [15:0] entry_index;
      logic [1:0]  key_type;
      logic [5:0]  key_id;
      logic [23:0] entry_value;
      logic        has_target;
      logic [23:0] target_rel;
      logic        text_leaf_candidate;
      logic [23:0] leaf_abs_offset;
      logic [1:0]  desc_status;
      logic [15:0] dir_length;
   } rsp_type;

   // Directory walk state carried from word to word
   typedef struct packed {
      logic        in_dir;
      logic [15:0] expected;
      logic [15:0] counter;
      phase_type   phase;
      logic [7:0]  base;
   } walk_type;

   typedef struct packed {
      logic [15:0] entry_cap;
      logic [5:0]  owner_key_id;
   } csr_type;

   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

// ===== hdl/crdp_entry_decode.sv =====
module crdp_entry_decode (
   input  crdp_pkg::req_type  req,
   input  crdp_pkg::walk_type walk,
   input  crdp_pkg::csr_type  csr,
   output crdp_pkg::rsp_type  rsp,
   output crdp_pkg::walk_type walk_next
);
   import crdp_pkg::*;

   logic [31:0]  q;
   logic [15:0]  idx;
   key_kind_type kt;
   logic [5:0]   kid;
   logic [23:0]  val;
   logic [24:0]  rel_sum;
   logic         is_ref;
   logic         tgt;
   logic [23:0]  rel;
   logic [15:0]  limit;
   logic [15:0]  hdr_count;

   assign q         = swap32(req.quadlet_word);
   assign hdr_count = q[31:16];
   assign idx       = walk.counter + 16'd1;
   assign kt        = key_kind_type'(q[31:30]);
   assign kid       = q[29:24];
   assign val       = q[23:0];
   assign is_ref    = (kt == KT_LEAF) || (kt == KT_DIRECTORY);
   // index plus sign-extended offset, 25 bits cannot overflow
   assign rel_sum   = {9'd0, idx} + {val[23], val};
   assign tgt       = is_ref && !rel_sum[24];
   assign rel       = tgt ? rel_sum[23:0] : 24'd0;
   assign limit     = (walk.expected < csr.entry_cap) ? walk.expected : csr.entry_cap;

   always_comb begin
      phase_type ph;
      logic [1:0] st;
      rsp       = '0;
      walk_next = walk;
      ph        = walk.phase;
      st        = ST_PENDING;
      if (req.is_header) begin
         walk_next.expected = hdr_count;
         walk_next.counter  = '0;
         walk_next.base     = req.dir_base;
         walk_next.in_dir   = !(hdr_count == '0 || csr.entry_cap == '0 || req.is_last);
         walk_next.phase    = walk_next.in_dir ? PH_SEARCH : PH_ABSENT;
         rsp.desc_status    = walk_next.in_dir ? ST_PENDING : ST_ABSENT;
         rsp.dir_length     = hdr_count;
      end else if (!walk.in_dir) begin
         rsp.desc_status = (walk.phase == PH_ABSENT) ? ST_ABSENT : ST_PENDING;
         rsp.dir_length  = walk.expected;
      end else begin
         walk_next.counter = idx;
         rsp.entry_valid   = 1'b1;
         rsp.entry_index   = idx;
         rsp.key_type      = q[31:30];
         rsp.key_id        = kid;
         rsp.entry_value   = val;
         rsp.has_target    = tgt;
         rsp.target_rel    = rel;
         rsp.dir_length    = walk.expected;
         if (tgt && kid == KEY_TEXT_DESC && kt == KT_LEAF) begin
            rsp.text_leaf_candidate = 1'b1;
            rsp.leaf_abs_offset     = {16'd0, walk.base} + rel;
         end
         unique case (walk.phase)
            PH_SEARCH: begin
               if (kt == KT_IMMEDIATE && kid == csr.owner_key_id) ph = PH_OWNER;
            end
            PH_OWNER: begin
               if (kid == KEY_TEXT_DESC && tgt && rel != '0) begin
                  ph = PH_FOUND;
                  st = ST_FOUND;
               end else begin
                  ph = PH_ABSENT;
               end
            end
            default: ;
         endcase
         if (req.is_last || idx >= limit) begin
            walk_next.in_dir = 1'b0;
            if (ph == PH_SEARCH || ph == PH_OWNER) ph = PH_ABSENT;
         end
         if (ph == PH_ABSENT) st = ST_ABSENT;
         walk_next.phase = ph;
         rsp.desc_status = st;
      end
   end

endmodule

// ===== hdl/config_rom_directory_parser_unit.sv =====
// Configuration ROM directory parser.
// req channel: one directory quadlet per word (big-endian), with is_header
//   marking the header that opens a directory, is_last marking the last
//   quadlet on hand, and dir_base giving the header's absolute offset.
// rsp channel: exactly one result word per accepted req word, in order:
//   decoded key type/id/value, relative and absolute targets, and the status
//   of the search for the owner entry's textual descriptor.
// csr channel: always ready; index 0 writes entry_cap, index 1 writes
//   owner_key_id, other indexes are dropped. Write only while idle.
// Results are registered; the decode is a single pass of shallow logic from
//   the req port into the result register (or the skid register, see Stall).
// Throughput: one word per cycle while req_ready is high.
// Stall: a two-entry output (result register plus skid register) lets one
//   more word in while a result waits; req_ready drops once the skid is full.
// Reset: synchronous; clears the walk state and output valids and restores
//   entry_cap to 65535 and owner_key_id to 3.
module config_rom_directory_parser_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  crdp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output crdp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import crdp_pkg::*;

   csr_type  csr_ff,  csr_in;
   walk_type walk_ff, walk_in;
   rsp_type  out_ff,  out_in;
   rsp_type  skid_ff, skid_in;
   logic     out_valid_ff, out_valid_in;
   logic     skid_valid_ff, skid_valid_in;

   rsp_type  result;
   walk_type walk_next;
   logic     accept;
   logic     rsp_take;

   assign csr_ready = 1'b1;
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign rsp_take  = out_valid_ff && rsp_ready;

   crdp_entry_decode u_decode (
      .req       (req_data),
      .walk      (walk_ff),
      .csr       (csr_ff),
      .rsp       (result),
      .walk_next (walk_next)
   );

   // Config writes: narrow the data to each register's width
   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         if (csr_index == CSR_ENTRY_CAP)    csr_in.entry_cap    = csr_wdata;
         if (csr_index == CSR_OWNER_KEY_ID) csr_in.owner_key_id = csr_wdata[5:0];
      end
   end

   // Advance the directory walk only on an accepted word
   assign walk_in = accept ? walk_next : walk_ff;

   // Output register with skid: drain the skid first, else load the new result
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || rsp_take) begin
         out_valid_in = accept;
         out_in       = result;
      end else if (accept) begin
         // result register held by the receiver: park the new word
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.entry_cap    <= ENTRY_CAP_RESET;
         csr_ff.owner_key_id <= OWNER_KEY_ID_RESET;
         walk_ff             <= '{in_dir: 1'b0, expected: '0, counter: '0,
                                  phase: PH_SEARCH, base: '0};
         out_valid_ff        <= 1'b0;
         skid_valid_ff       <= 1'b0;
      end else begin
         csr_ff        <= csr_in;
         walk_ff       <= walk_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // The skid only fills behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word without result word");

   // A word taken while the result stalls must land in the skid
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (accept && out_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("word lost under output stall");

   // Decoded entries are never numbered zero
   a_entry_index: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.entry_valid) |-> (out_ff.entry_index != '0))
      else $error("entry with index zero");

   // No target means no relative target and no text leaf flag
   a_target_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.has_target) |->
         (out_ff.target_rel == '0 && !out_ff.text_leaf_candidate))
      else $error("target fields set without target");

endmodule
